// ===== design/sxrm_pkg.sv =====
package sxrm_pkg;

    localparam logic [63:0] MIX_MULT    = 64'd2685821657736338717;
    localparam int          MIX_SHIFT_A = 12;
    localparam int          MIX_SHIFT_B = 25;
    localparam int          MIX_SHIFT_C = 27;

    localparam int          DIV_STAGES  = 64;
    // seed/mul stages A, B, C, D, then the divider, then the output register
    localparam int          PRE_STAGES  = 4;
    localparam int          NUM_STAGES  = PRE_STAGES + DIV_STAGES + 1;

    localparam logic [63:0] MODULUS_RESET = 64'd65535;

    typedef enum logic [0:0] {
        REG_OFFSET  = 1'b0,
        REG_MODULUS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] pll;
        logic [31:0] plh;
        logic [31:0] phl;
    } part_prod_t;

endpackage

// ===== design/seeded_xorshift_range_mapper_unit.sv =====
// Seeded xorshift range mapper.
// Input beat: entropy_low and position (in_valid / in_ready). Output beat:
// random_value and zero_modulus (out_valid / out_ready), one per input beat,
// in order. Each beat forms seed = entropy_low << 32, adds position times the
// xorshift64* constant, mixes by xorshift 12/25/27 and a second multiply, then
// returns offset + (mixed mod modulus) wrapped to 64 bits. A zero modulus
// returns offset with zero_modulus set.
// Pipeline: 69 register stages. Throughput: one beat per cycle while
// out_ready is high, as a stalled receiver holds the pipeline once it fills;
// four seed/multiply stages (32x32 partial products, then their sums) feed a
// 64-stage restoring divider (one quotient bit per stage).
// Each stage holds its beat only while the stage after it is full and stalled,
// so a stalled receiver lets empty stages keep filling; in_ready drops only
// when every stage is full. Nothing is lost or repeated on a stall.
// Reset clears all stage valid bits, offset to 0 and modulus to 65535.
// The user writes configuration (cfg_wr_en, cfg_index, cfg_data) only while
// the pipeline is empty (not enforced); index 0 is offset, index 1 is modulus.
module seeded_xorshift_range_mapper_unit
    import sxrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] entropy_low,
    input  logic [63:0] position,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] random_value,
    output logic        zero_modulus
);

    localparam int LAST = NUM_STAGES - 1;

    logic [63:0]      offset_reg;
    logic [63:0]      modulus_reg;

    logic             valid_reg [NUM_STAGES];
    logic             ready     [NUM_STAGES];

    logic [31:0]      seed_a_reg;
    part_prod_t       prod_a_reg;
    part_prod_t       prod_a_next;
    logic [63:0]      xs_b_reg;
    logic [63:0]      xs_b_next;
    part_prod_t       prod_c_reg;
    part_prod_t       prod_c_next;
    logic [63:0]      mixed_d_reg;
    logic [63:0]      mixed_d_next;

    logic [63:0]      rem_reg  [DIV_STAGES];
    logic [63:0]      num_reg  [DIV_STAGES];
    logic [63:0]      rem_next [DIV_STAGES];
    logic [63:0]      num_next [DIV_STAGES];

    logic [63:0]      result_reg;
    logic [63:0]      result_next;
    logic             zero_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OFFSET:  offset_reg  <= cfg_data;
                REG_MODULUS: modulus_reg <= cfg_data;
                default:     offset_reg  <= offset_reg;
            endcase
        end
    end

    // per-stage ready: a stage may load when empty or when its successor moves
    always_comb
    begin
        ready[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
    end

    assign in_ready = ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
        end
    end

    // stage A: partial products of position * MIX_MULT (low 64 bits only)
    always_comb
    begin
        prod_a_next.pll = position[31:0] * MIX_MULT[31:0];
        prod_a_next.plh = 32'(position[31:0] * MIX_MULT[63:32]);
        prod_a_next.phl = 32'(position[63:32] * MIX_MULT[31:0]);
    end

    // stage B: seed sum and xorshift mix
    always_comb
    begin
        logic [63:0] x;
        x = {seed_a_reg, 32'd0} + prod_a_reg.pll
            + {prod_a_reg.plh + prod_a_reg.phl, 32'd0};
        x = x ^ (x >> MIX_SHIFT_A);
        x = x ^ (x << MIX_SHIFT_B);
        x = x ^ (x >> MIX_SHIFT_C);
        xs_b_next = x;
    end

    // stage C: partial products of the final multiply
    always_comb
    begin
        prod_c_next.pll = xs_b_reg[31:0] * MIX_MULT[31:0];
        prod_c_next.plh = 32'(xs_b_reg[31:0] * MIX_MULT[63:32]);
        prod_c_next.phl = 32'(xs_b_reg[63:32] * MIX_MULT[31:0]);
    end

    // stage D: sum of partial products
    assign mixed_d_next = prod_c_reg.pll + {prod_c_reg.plh + prod_c_reg.phl, 32'd0};

    // divider: one restoring step per stage, dividend shifts out msb first
    always_comb
    begin
        logic [64:0] r;
        logic [63:0] n;
        logic [63:0] rp;
        logic [65:0] diff;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rp = (k == 0) ? 64'd0 : rem_reg[(k == 0) ? 0 : k - 1];
            n  = (k == 0) ? mixed_d_reg : num_reg[(k == 0) ? 0 : k - 1];
            r  = {rp, n[63]};
            diff = {1'b0, r} - {2'b00, modulus_reg};
            rem_next[k] = diff[65] ? r[63:0] : diff[63:0];
            num_next[k] = {n[62:0], 1'b0};
        end
    end

    // output stage: zero modulus passes offset alone
    assign result_next = (modulus_reg == 64'd0) ? offset_reg
                                                : offset_reg + rem_reg[DIV_STAGES - 1];

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            seed_a_reg <= entropy_low;
            prod_a_reg <= prod_a_next;
        end
        if (ready[1])
        begin
            xs_b_reg <= xs_b_next;
        end
        if (ready[2])
        begin
            prod_c_reg <= prod_c_next;
        end
        if (ready[3])
        begin
            mixed_d_reg <= mixed_d_next;
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (ready[PRE_STAGES + k])
            begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
            end
        end
        if (ready[LAST])
        begin
            result_reg <= result_next;
            zero_reg   <= (modulus_reg == 64'd0);
        end
    end

    assign out_valid    = valid_reg[LAST];
    assign random_value = result_reg;
    assign zero_modulus = zero_reg;

endmodule
